[hw/rtl/ccl_pkg.sv]
package ccl_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_RULE_ENABLES   = 8'd0;
    localparam logic [7:0] REG_MAX_CHARGE     = 8'd1;
    localparam logic [7:0] REG_RAMP_WINDOW    = 8'd2;
    localparam logic [7:0] REG_RAMP_FLOOR     = 8'd3;
    localparam logic [7:0] REG_SOC_RULE       = 8'd4;
    localparam logic [7:0] REG_DRIFT_RULE     = 8'd5;
    localparam logic [7:0] REG_CUTOFF_TICKS   = 8'd6;
    localparam logic [7:0] REG_CUTOFF_RULE    = 8'd7;

    localparam int CFG_DATA_W = 48;

    // shared divider width: (65535 * 100) needs 23 bits
    localparam int DIV_W = 23;
    localparam int CNT_W = 5;

    // wide compare width for amps values
    localparam int WW = 16;

    // step limiter bands and steps
    localparam logic [WW-1:0] BAND_HI   = 16'd50;
    localparam logic [WW-1:0] BAND_MID  = 16'd25;
    localparam logic [WW-1:0] BAND_LO   = 16'd10;
    localparam logic [WW-1:0] STEP_HI   = 16'd10;
    localparam logic [WW-1:0] STEP_MID  = 16'd5;
    localparam logic [WW-1:0] STEP_LO   = 16'd3;
    localparam logic [WW-1:0] STEP_MIN  = 16'd1;
    localparam logic [WW-1:0] STEP_UP   = 16'd10;

    localparam int IN_W = 64;

endpackage

[hw/rtl/charge_current_limiter.sv]
// Charge current limiter.
// Input channel s_*: one item per tick with battery measurements, packed in
// s_tdata. Result channel m_*: one item per input item, the new setpoint and
// the four derated limits. Configuration channel cfg_*: register writes by
// index, always ready; write only while the block is idle.
// An item is taken when the block is idle (s_tready high). It then passes a
// rules step and a final step; when the voltage ramp runs, two passes of the
// shared restoring divider (mV per step, then amps of change) come between
// them. The divider sets the throughput; a new item is taken only once the
// block is back in idle.
// The result sits in an output register; the next item may be accepted while
// it waits. If the receiver stalls, the final step holds until the output
// register is free, so nothing is lost.
// Reset (aresetn low, synchronous) clears all configuration registers, the
// last setpoint and the cutoff timer, and empties the output register.
module charge_current_limiter
    import ccl_pkg::*;
#(
    parameter int AMP_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tdata from bit 0: alarm_zero, multi_pack, pack_sum_amps[12],
    // max_cell_mv[13], cell_drift_mv[13], soc_percent[7], battery_deciamps[16]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,
    // tdata from bit 0: setpoint_amps, voltage_limit_amps, soc_limit_amps,
    // drift_limit_amps, cutoff_limit_amps, each AMP_BITS wide
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((5*AMP_BITS+7)/8)*8-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [7:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int OUT_W = ((5*AMP_BITS+7)/8)*8;
    localparam logic [WW-1:0] AMP_MAX = WW'((1 << AMP_BITS) - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_RULES, ST_DIV1, ST_DIV2, ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2:0]  en_reg;
    logic [9:0]  max_reg;
    logic [31:0] window_reg;
    logic [9:0]  floor_reg;
    logic [15:0] soc_rule_reg;
    logic [47:0] drift_rule_reg;
    logic [15:0] ticks_reg;
    logic [23:0] cut_rule_reg;

    // state
    logic [AMP_BITS-1:0] last_reg, last_next;
    logic [15:0]         timer_reg, timer_next;

    // latched item
    logic        alarm_reg;
    logic        multi_reg;
    logic [11:0] psum_reg;
    logic [12:0] vmax_reg;
    logic [12:0] drift_reg;
    logic [6:0]  soc_reg;
    logic signed [15:0] deci_reg;

    // working registers
    logic [AMP_BITS-1:0] base_reg, base_next;
    logic [AMP_BITS-1:0] volt_reg, volt_next;
    logic [AMP_BITS-1:0] soclim_reg, soclim_next;
    logic [28:0]         dprod_reg, dprod_next;
    logic                dact_reg, dact_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic accept;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // shared restoring divider step
    logic [DIV_W:0]   div_shift;
    logic             div_ge;
    logic [DIV_W-1:0] div_rem;
    logic [DIV_W-1:0] div_quo;
    always_comb begin
        div_shift = {rem_reg, quo_reg[DIV_W-1]};
        div_ge    = (div_shift >= {1'b0, dvsr_reg});
        div_rem   = div_ge ? DIV_W'(div_shift - {1'b0, dvsr_reg}) : div_shift[DIV_W-1:0];
        div_quo   = {quo_reg[DIV_W-2:0], div_ge};
    end

    // combinational rule values
    logic [WW-1:0] base_w, psum_w, floor_w, span_w, last_w;
    logic [15:0]   r_start, r_end;
    logic [DIV_W-1:0] r_num1, r_num2;
    logic          v_bypass, v_floor;
    logic [7:0]    s_start, s_per;
    logic [15:0]   s_red;
    logic [WW-1:0] s_red_w;
    logic [15:0]   d_start, d_min, d_apm;
    logic [AMP_BITS-1:0] d_lim, c_lim, target, sp;
    logic [15:0]   c_cur;
    logic [7:0]    c_soc;
    logic signed [20:0] c_thr;
    logic          c_low;
    logic [WW-1:0] dec_w, sp_w;
    logic          out_free;

    always_comb begin
        psum_w  = WW'(psum_reg);
        floor_w = WW'(floor_reg);
        base_w  = (WW'(max_reg) > AMP_MAX) ? AMP_MAX : WW'(max_reg);
        if (multi_reg && psum_w < base_w) begin
            base_w = psum_w;
        end
        r_start = window_reg[15:0];
        r_end   = window_reg[31:16];
        // x*100 for both ramp dividends
        r_num1  = DIV_W'({7'd0, r_end - r_start} * 23'd100);
        r_num2  = DIV_W'({10'd0, vmax_reg - r_start[12:0]} * 23'd100);
        span_w  = WW'(base_reg) - floor_w;
        v_bypass = !en_reg[0] || (WW'(r_start) > WW'(vmax_reg)) || (r_start > r_end)
                   || (base_w <= floor_w);
        v_floor  = (WW'(vmax_reg) > WW'(r_end));

        s_start = soc_rule_reg[7:0];
        s_per   = soc_rule_reg[15:8];
        s_red   = 16'({8'd0, s_start} > {9'd0, soc_reg} ? 16'd0
                      : ({9'd0, soc_reg} - {8'd0, s_start} + 16'd1) * {8'd0, s_per});
        s_red_w = s_red;

        d_start = drift_rule_reg[15:0];
        d_min   = drift_rule_reg[31:16];
        d_apm   = drift_rule_reg[47:32];

        d_lim = base_reg;
        if (dact_reg) begin
            d_lim = (29'(base_reg) >= dprod_reg) ? AMP_BITS'(29'(base_reg) - dprod_reg)
                                                 : '0;
        end

        // amps = deci/10 toward zero; amps < c_cur without a divider
        c_cur = cut_rule_reg[15:0];
        c_soc = cut_rule_reg[23:16];
        c_thr = $signed({5'd0, c_cur}) * 21'sd10;
        c_low = (21'(deci_reg) < c_thr) && !((c_cur == 16'd0) && (deci_reg > -16'sd10));

        timer_next = timer_reg;
        c_lim      = base_reg;
        if (ticks_reg != 16'd0) begin
            if (timer_reg >= ticks_reg) begin
                if ({1'b0, soc_reg} < c_soc) begin
                    timer_next = '0;
                end else begin
                    c_lim = '0;
                end
            end else if (c_low && ({1'b0, soc_reg} >= c_soc)) begin
                timer_next = timer_reg + 16'd1;
            end else begin
                timer_next = '0;
            end
        end

        target = base_reg;
        if (volt_reg < target)   target = volt_reg;
        if (soclim_reg < target) target = soclim_reg;
        if (d_lim < target)      target = d_lim;
        if (c_lim < target)      target = c_lim;

        last_w = WW'(last_reg);
        if (last_w >= BAND_HI)       dec_w = STEP_HI;
        else if (last_w >= BAND_MID) dec_w = STEP_MID;
        else if (last_w >= BAND_LO)  dec_w = STEP_LO;
        else                         dec_w = STEP_MIN;
        if (WW'(target) < last_w) begin
            sp_w = (last_w >= dec_w) ? last_w - dec_w : '0;
        end else if (WW'(target) - last_w > STEP_UP) begin
            sp_w = last_w + STEP_UP;
        end else begin
            sp_w = WW'(target);
        end
        sp = sp_w[AMP_BITS-1:0];
    end

    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        base_next    = base_reg;
        volt_next    = volt_reg;
        soclim_next  = soclim_reg;
        dprod_next   = dprod_reg;
        dact_next    = dact_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvsr_next    = dvsr_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RULES;
                end
            end
            ST_RULES: begin
                base_next   = base_w[AMP_BITS-1:0];
                soclim_next = (base_w >= s_red_w) ? AMP_BITS'(base_w - s_red_w) : '0;
                if (!en_reg[1] || ({1'b0, soc_reg} < s_start)) begin
                    soclim_next = base_w[AMP_BITS-1:0];
                end
                dact_next  = en_reg[2] && (drift_reg != 13'd0) && (16'(drift_reg) > d_start)
                             && (16'(vmax_reg) >= d_min);
                dprod_next = 29'(drift_reg - d_start[12:0]) * 29'(d_apm);
                quo_next   = r_num1;
                rem_next   = '0;
                dvsr_next  = DIV_W'(base_w - floor_w);
                cnt_next   = CNT_W'(DIV_W - 1);
                if (alarm_reg) begin
                    state_next = ST_FIN;
                end else if (v_bypass) begin
                    volt_next  = base_w[AMP_BITS-1:0];
                    state_next = ST_FIN;
                end else if (v_floor) begin
                    volt_next  = AMP_BITS'(floor_reg);
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                quo_next = div_quo;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (div_quo == '0) begin
                        // zero mV per step: ramp gives the floor
                        volt_next  = AMP_BITS'(floor_reg);
                        state_next = ST_FIN;
                    end else begin
                        quo_next   = r_num2;
                        rem_next   = '0;
                        dvsr_next  = div_quo;
                        cnt_next   = CNT_W'(DIV_W - 1);
                        state_next = ST_DIV2;
                    end
                end
            end
            ST_DIV2: begin
                quo_next = div_quo;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (div_quo > DIV_W'(span_w)) begin
                        volt_next = AMP_BITS'(floor_reg);
                    end else begin
                        volt_next = AMP_BITS'(WW'(base_reg) - div_quo[WW-1:0]);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (alarm_reg) begin
                        last_next   = '0;
                        m_data_next = '0;
                    end else begin
                        last_next   = sp;
                        m_data_next = OUT_W'({c_lim, d_lim, soclim_reg, volt_reg, sp});
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            last_reg       <= '0;
            timer_reg      <= '0;
            en_reg         <= '0;
            max_reg        <= '0;
            window_reg     <= '0;
            floor_reg      <= '0;
            soc_rule_reg   <= '0;
            drift_rule_reg <= '0;
            ticks_reg      <= '0;
            cut_rule_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
            if (state_reg == ST_FIN && out_free && !alarm_reg) begin
                timer_reg <= timer_next;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RULE_ENABLES: en_reg         <= cfg_data[2:0];
                    REG_MAX_CHARGE:   max_reg        <= cfg_data[9:0];
                    REG_RAMP_WINDOW:  window_reg     <= cfg_data[31:0];
                    REG_RAMP_FLOOR:   floor_reg      <= cfg_data[9:0];
                    REG_SOC_RULE:     soc_rule_reg   <= cfg_data[15:0];
                    REG_DRIFT_RULE:   drift_rule_reg <= cfg_data[47:0];
                    REG_CUTOFF_TICKS: ticks_reg      <= cfg_data[15:0];
                    REG_CUTOFF_RULE:  cut_rule_reg   <= cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            alarm_reg <= s_tdata[0];
            multi_reg <= s_tdata[1];
            psum_reg  <= s_tdata[13:2];
            vmax_reg  <= s_tdata[26:14];
            drift_reg <= s_tdata[39:27];
            soc_reg   <= s_tdata[46:40];
            deci_reg  <= s_tdata[62:47];
        end
        base_reg   <= base_next;
        volt_reg   <= volt_next;
        soclim_reg <= soclim_next;
        dprod_reg  <= dprod_next;
        dact_reg   <= dact_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (dvsr_reg != '0))
        else $error("divider running with zero divisor");

    // an alarm item delivers all zero fields
    a_alarm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free && alarm_reg) |=> (m_tdata == '0))
        else $error("alarm item with nonzero result");

    // setpoint rises by at most the up step
    a_step_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free)
        |=> (WW'(last_reg) <= WW'($past(last_reg)) + STEP_UP))
        else $error("setpoint rose too fast");

endmodule
